[rtl/vq_nearest_codeword_search_core_assert.svh]
// Assertion macros for the nearest codeword search core.
`ifndef VQ_NEAREST_CODEWORD_SEARCH_CORE_ASSERT_SVH
`define VQ_NEAREST_CODEWORD_SEARCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define VQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("vq assertion failed");
`define VQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("vq assertion failed");
`else
`define VQ_ASSERT(lbl, clk, rstn, prop)
`define VQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/vq_pkg.sv]
`timescale 1ns / 1ps
package vq_pkg;
  localparam int MaxCodesDef   = 256;
  localparam int MaxDimsDef    = 16;
  localparam int SampleBitsDef = 16;
  localparam int CodeBits      = 8;
  localparam int DimBits       = 4;
  localparam int ValBits       = 16;
  localparam int DistBits      = 36;
  localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};
  localparam int CfgIdxBits    = 1;
  localparam int CfgDataBits   = 9;
  localparam logic [CfgIdxBits-1:0] CfgCodes = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgDims  = 1'b1;
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
  } tok_t;
endpackage

[rtl/vq_stream_if.sv]
`timescale 1ns / 1ps
interface vq_in_if;
  import vq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [CodeBits-1:0]        code_index;
  logic [DimBits-1:0]         dim_index;
  logic signed [ValBits-1:0]  sample_value;
  logic                       last_element;
  modport source (output valid, mode, code_index, dim_index, sample_value, last_element,
                  input ready);
  modport sink (input valid, mode, code_index, dim_index, sample_value, last_element,
                output ready);
endinterface

interface vq_out_if;
  import vq_pkg::*;
  logic                valid;
  logic                ready;
  logic [CodeBits-1:0] best_code;
  logic [DistBits-1:0] best_distance;
  modport source (output valid, best_code, best_distance, input ready);
  modport sink (input valid, best_code, best_distance, output ready);
endinterface

[rtl/vq_cell.sv]
`timescale 1ns / 1ps
module vq_cell import vq_pkg::*; #(
  parameter int MAX_CODES   = MaxCodesDef,
  parameter int SAMPLE_BITS = SampleBitsDef,
  localparam int CW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [CW-1:0]                 wr_addr_i,
  input  logic signed [SAMPLE_BITS-1:0] wr_data_i,
  input  logic                          q_we_i,
  input  logic                          active_i,
  input  tok_t                          tok_i,
  input  logic [CW-1:0]                 code_i,
  input  logic [DistBits-1:0]           sum_i,
  output tok_t                          tok_o,
  output logic [CW-1:0]                 code_o,
  output logic [DistBits-1:0]           sum_o
);
  localparam int DW   = SAMPLE_BITS + 1;
  localparam int SqW  = 2 * DW;
  localparam int AccW = ((SqW > DistBits) ? SqW : DistBits) + 1;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_CODES];
  logic signed [SAMPLE_BITS-1:0] rd_q, qv_q;
  logic signed [DW-1:0]          diff;
  logic [SqW-1:0]                sq_q;
  tok_t                          tok1_q, tok2_q, tok3_q;
  logic [CW-1:0]                 code1_q, code2_q, code3_q;
  logic [DistBits-1:0]           sum1_q, sum2_q, sum3_q;
  logic [AccW-1:0]               acc;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[code_i];
  end

  always_ff @(posedge clk_i) begin
    if (q_we_i) begin
      qv_q <= wr_data_i;
    end
  end

  assign diff = DW'(qv_q) - DW'(rd_q);

  always_comb begin
    acc = AccW'(sum2_q) + (active_i ? AccW'(sq_q) : AccW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
      tok2_q <= '0;
      tok3_q <= '0;
    end else begin
      tok1_q <= tok_i;
      tok2_q <= tok1_q;
      tok3_q <= tok2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    code1_q <= code_i;
    sum1_q  <= sum_i;
    code2_q <= code1_q;
    sum2_q  <= sum1_q;
    sq_q    <= SqW'($unsigned(SqW'(diff) * SqW'(diff)));
    code3_q <= code2_q;
    sum3_q  <= (acc > AccW'(DistMax)) ? DistMax : acc[DistBits-1:0];
  end

  assign tok_o  = tok3_q;
  assign code_o = code3_q;
  assign sum_o  = sum3_q;
endmodule

[rtl/vq_best.sv]
`timescale 1ns / 1ps
module vq_best import vq_pkg::*; #(
  parameter int MAX_CODES = MaxCodesDef,
  localparam int CW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tok_t                tok_i,
  input  logic [CW-1:0]       code_i,
  input  logic [DistBits-1:0] sum_i,
  vq_out_if.source            res_o
);
  logic [CW-1:0]       best_code_q, best_code_d;
  logic [DistBits-1:0] best_dist_q, best_dist_d;
  logic [CodeBits-1:0] out_code_q;
  logic [DistBits-1:0] out_dist_q;
  logic                out_valid_q;

  always_comb begin
    best_code_d = best_code_q;
    best_dist_d = best_dist_q;
    if (code_i == '0 || sum_i < best_dist_q) begin
      best_code_d = code_i;
      best_dist_d = sum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      best_code_q <= best_code_d;
      best_dist_q <= best_dist_d;
    end
    if (tok_i.valid && tok_i.last) begin
      out_code_q <= CodeBits'(best_code_d);
      out_dist_q <= best_dist_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tok_i.valid && tok_i.last) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.best_code     = out_code_q;
  assign res_o.best_distance = out_dist_q;
endmodule

[rtl/vq_nearest_codeword_search_core.sv]
// After the last query element is taken, the search waits while the previous result is
// still unread at the output, then streams the codebook through the cells.
// One codeword per cycle streams through the row of per-dimension cells;
// no new query element or codebook write is accepted until the search ends.
// Reset clears control and configuration (codes_in_use = 1, dims_in_use = 1);
// codebook and query storage are undefined until written.
`timescale 1ns / 1ps
`include "vq_nearest_codeword_search_core_assert.svh"
module vq_nearest_codeword_search_core import vq_pkg::*; #(
  parameter int MAX_CODES   = MaxCodesDef,
  parameter int MAX_DIMS    = MaxDimsDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  vq_in_if.sink                  in_i,
  vq_out_if.source               res_o
);
  localparam int CW   = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam int ExtW = (SAMPLE_BITS > ValBits) ? SAMPLE_BITS : ValBits;
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWait  = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;
  localparam logic [1:0] StDrain = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [8:0]             codes_q;
  logic [4:0]             dims_q;
  logic [CW-1:0]          last_code_q, cnt_q;
  logic [CW-1:0]          ncodes_m1;
  int unsigned            ndims;
  tok_t                   iss_tok_q;
  logic [CW-1:0]          iss_code_q;
  logic                   in_fire, launch, busy, done;
  logic [ExtW-1:0]        ext;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                   wr_ok;

  tok_t                   tok   [MAX_DIMS+1];
  logic [CW-1:0]          code  [MAX_DIMS+1];
  logic [DistBits-1:0]    sum   [MAX_DIMS+1];

  assign busy     = (state_q != StIdle);
  assign in_i.ready = !busy;
  assign in_fire  = in_i.valid && in_i.ready;
  assign launch   = in_fire && in_i.mode == ModeQuery && in_i.last_element;
  assign done     = tok[MAX_DIMS].valid && tok[MAX_DIMS].last;
  assign ext      = ExtW'($unsigned(in_i.sample_value));
  assign sample   = ext[SAMPLE_BITS-1:0];
  assign wr_ok    = in_fire && in_i.mode == ModeWrite &&
                    int'(in_i.code_index) < MAX_CODES && int'(in_i.dim_index) < MAX_DIMS;

  always_comb begin
    if (codes_q == 9'd0) begin
      ncodes_m1 = '0;
    end else if (int'(codes_q) > MAX_CODES) begin
      ncodes_m1 = CW'(MAX_CODES - 1);
    end else begin
      ncodes_m1 = CW'(codes_q - 9'd1);
    end
    if (dims_q == 5'd0) begin
      ndims = 1;
    end else if (int'(dims_q) > MAX_DIMS) begin
      ndims = MAX_DIMS;
    end else begin
      ndims = int'(dims_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= 9'd1;
      dims_q  <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCodes: codes_q <= cfg_data_i;
        CfgDims:  dims_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (launch) state_d = res_o.valid ? StWait : StRun;
      StWait:  if (!res_o.valid) state_d = StRun;
      StRun:   if (cnt_q == last_code_q) state_d = StDrain;
      StDrain: if (done) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      iss_tok_q <= '0;
    end else begin
      state_q         <= state_d;
      iss_tok_q.valid <= (state_q == StRun);
      iss_tok_q.last  <= (state_q == StRun) && (cnt_q == last_code_q);
      if (state_q == StRun) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_code_q <= cnt_q;
    if (launch) begin
      last_code_q <= ncodes_m1;
    end
  end

  assign tok[0]  = iss_tok_q;
  assign code[0] = iss_code_q;
  assign sum[0]  = '0;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    vq_cell #(.MAX_CODES(MAX_CODES), .SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_ok && int'(in_i.dim_index) == d),
      .wr_addr_i (CW'(in_i.code_index)),
      .wr_data_i (sample),
      .q_we_i    (in_fire && in_i.mode == ModeQuery && int'(in_i.dim_index) == d),
      .active_i  (d < ndims),
      .tok_i     (tok[d]),
      .code_i    (code[d]),
      .sum_i     (sum[d]),
      .tok_o     (tok[d+1]),
      .code_o    (code[d+1]),
      .sum_o     (sum[d+1])
    );
  end

  vq_best #(.MAX_CODES(MAX_CODES)) u_best (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok[MAX_DIMS]),
    .code_i (code[MAX_DIMS]),
    .sum_i  (sum[MAX_DIMS]),
    .res_o  (res_o)
  );

  `VQ_ASSERT(a_chain_only_busy, clk_i, rst_ni, tok[MAX_DIMS].valid |-> busy)
  `VQ_ASSERT(a_run_out_free, clk_i, rst_ni, (state_q == StRun) |-> !res_o.valid)
  `VQ_ASSERT(a_result_from_search, clk_i, rst_ni, $rose(res_o.valid) |-> $past(busy))
  `VQ_ASSERT_ALWAYS(a_no_fire_busy, clk_i, in_fire |-> !busy)
endmodule

[tb/sv/tb_vq_nearest_codeword_search_core.sv]
`timescale 1ns / 1ps
module tb_vq_nearest_codeword_search_core;
  import vq_pkg::*;

  localparam int NumCodes   = MaxCodesDef;
  localparam int NumDims    = MaxDimsDef;
  localparam int DrainWait  = NumCodes + 3 * NumDims + 3 + 100;
  localparam int ItemsPhase = 183;

  typedef enum logic [2:0] {
    RowCfg, RowWrite, RowQuery, RowFillCode, RowFillQuery
  } row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIdxBits-1:0]    cfg_idx;
    logic [CfgDataBits-1:0]   cfg_val;
    logic [CodeBits-1:0]      code;
    logic [DimBits-1:0]       dim;
    logic signed [ValBits-1:0] val;
    logic                     last;
    bit                       typed;
    logic [CodeBits-1:0]      exp_code;
    logic [DistBits-1:0]      exp_distance;
  } stim_row_t;

  typedef struct packed {
    logic [CodeBits-1:0] code;
    logic [DistBits-1:0] distance;
  } nearest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  vq_in_if  in_if ();
  vq_out_if res_if ();

  vq_nearest_codeword_search_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .res_o      (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic signed [ValBits-1:0] codebook [NumCodes][NumDims];
  bit                        codebook_set [NumCodes][NumDims];
  logic signed [ValBits-1:0] query_vec [NumDims];
  bit                        query_set [NumDims];
  logic [CfgDataBits-1:0]    reg_codes = 9'd1;
  logic [4:0]                reg_dims = 5'd1;
  nearest_t                  nearest_q[$];
  int                        fails = 0;
  int                        snd_pct = 10;
  int                        rcv_pct = 61;
  stim_row_t                 rows[$];

  function automatic int active_codes();
    if (reg_codes < 1) return 1;
    if (reg_codes > NumCodes) return NumCodes;
    return reg_codes;
  endfunction

  function automatic int active_dims();
    if (reg_dims < 1) return 1;
    if (reg_dims > NumDims) return NumDims;
    return reg_dims;
  endfunction

  function automatic logic [DistBits-1:0] code_distance(int c, int nd);
    longint sum;
    longint diff;
    sum = 0;
    for (int d = 0; d < nd; d++) begin
      diff = longint'(query_vec[d]) - longint'(codebook[c][d]);
      sum += diff * diff;
      if (sum > longint'(DistMax)) sum = longint'(DistMax);
    end
    return sum[DistBits-1:0];
  endfunction

  function automatic nearest_t nearest_search();
    nearest_t best;
    logic [DistBits-1:0] dd;
    best.code = '0;
    best.distance = code_distance(0, active_dims());
    for (int c = 1; c < active_codes(); c++) begin
      dd = code_distance(c, active_dims());
      if (dd < best.distance) begin
        best.distance = dd;
        best.code = c[CodeBits-1:0];
      end
    end
    return best;
  endfunction

  function automatic bit search_allowed();
    for (int d = 0; d < active_dims(); d++) begin
      if (!query_set[d]) return 0;
      for (int c = 0; c < active_codes(); c++)
        if (!codebook_set[c][d]) return 0;
    end
    return 1;
  endfunction

  function automatic logic signed [ValBits-1:0] rand_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return ValBits'($urandom());
  endfunction

  task automatic send_item(input logic mode, input logic [CodeBits-1:0] code,
                           input logic [DimBits-1:0] dim, input logic signed [ValBits-1:0] val,
                           input logic last, input bit typed = 0,
                           input logic [CodeBits-1:0] ecode = '0,
                           input logic [DistBits-1:0] edist = '0);
    nearest_t best;
    if ($urandom_range(99) < snd_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.code_index <= code;
    in_if.dim_index <= dim;
    in_if.sample_value <= val;
    in_if.last_element <= last;
    do @(posedge clk_i); while (!in_if.ready);
    if (mode == ModeWrite) begin
      codebook[code][dim] = val;
      codebook_set[code][dim] = 1;
    end else begin
      query_vec[dim] = val;
      query_set[dim] = 1;
      if (last) begin
        best = nearest_search();
        if (typed) begin
          best.code = ecode;
          best.distance = edist;
        end
        nearest_q.push_back(best);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
    in_if.valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgCodes) reg_codes = val;
    else reg_dims = val[4:0];
  endtask

  task automatic fill_missing(inout int count);
    for (int c = 0; c < active_codes(); c++)
      for (int d = 0; d < active_dims(); d++)
        if (!codebook_set[c][d]) begin
          send_item(ModeWrite, c[CodeBits-1:0], d[DimBits-1:0], rand_sample(),
                    1'($urandom_range(1)));
          count++;
        end
  endtask

  task automatic query_sequence(inout int count);
    int order[NumDims];
    int nd;
    int j;
    int t;
    nd = active_dims();
    fill_missing(count);
    repeat ($urandom_range(0, 3)) begin
      send_item(ModeWrite, CodeBits'($urandom_range(active_codes() - 1)),
                DimBits'($urandom_range(nd - 1)), rand_sample(), 1'($urandom_range(1)));
      count++;
    end
    for (int d = 0; d < nd; d++) order[d] = d;
    for (int d = nd - 1; d > 0; d--) begin
      j = $urandom_range(d);
      t = order[d];
      order[d] = order[j];
      order[j] = t;
    end
    for (int d = 0; d < nd; d++) begin
      send_item(ModeQuery, CodeBits'($urandom()), order[d][DimBits-1:0], rand_sample(),
                d == nd - 1);
      count++;
    end
  endtask

  task automatic noise_item(inout int count);
    logic [DimBits-1:0] dm;
    logic signed [ValBits-1:0] v;
    if ($urandom_range(1)) begin
      send_item(ModeWrite, CodeBits'($urandom()), DimBits'($urandom()), rand_sample(),
                1'($urandom_range(1)));
    end else begin
      dm = DimBits'($urandom());
      v = rand_sample();
      if (query_set[dm] || dm >= active_dims()) begin
        send_item(ModeQuery, CodeBits'($urandom()), dm, v,
                  search_allowed() && $urandom_range(1));
      end else begin
        send_item(ModeQuery, CodeBits'($urandom()), dm, v, 1'b0);
      end
    end
    count++;
  endtask

  function automatic stim_row_t mk_row(row_kind_e kind, logic [CfgIdxBits-1:0] ci,
                                       logic [CfgDataBits-1:0] cv, logic [CodeBits-1:0] code,
                                       logic [DimBits-1:0] dim, logic signed [ValBits-1:0] val,
                                       logic last, bit typed, logic [CodeBits-1:0] ec,
                                       logic [DistBits-1:0] ed);
    stim_row_t r;
    r.kind = kind; r.cfg_idx = ci; r.cfg_val = cv; r.code = code; r.dim = dim;
    r.val = val; r.last = last; r.typed = typed; r.exp_code = ec; r.exp_distance = ed;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nearest_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (nearest_q.size() == 0) begin
          $error("unexpected result code=%0d distance=%0d", res_if.best_code,
                 res_if.best_distance);
          fails++;
        end else begin
          want = nearest_q.pop_front();
          if (res_if.best_code !== want.code) begin
            $error("best_code expected %0d actual %0d", want.code, res_if.best_code);
            fails++;
          end
          if (res_if.best_distance !== want.distance) begin
            $error("best_distance expected %0d actual %0d", want.distance,
                   res_if.best_distance);
            fails++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("tb_vq_nearest_codeword_search_core NOT OK");
    $finish;
  end

  initial begin
    int count;
    int phase_codes[9];
    int phase_dims[9];
    stim_row_t r;
    in_if.valid = 1'b0;
    in_if.mode = ModeWrite;
    in_if.code_index = '0;
    in_if.dim_index = '0;
    in_if.sample_value = '0;
    in_if.last_element = 1'b0;
    phase_codes = '{1, 0, 3, 511, 2, 17, 256, 8, 40};
    phase_dims  = '{1, 0, 2, 1, 31, 5, 1, 16, 3};

    rows.push_back(mk_row(RowWrite, CfgCodes, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 0));
    rows.push_back(mk_row(RowQuery, CfgCodes, 0, 0, 0, 16'sh8000, 1, 1, 0, 36'd4294836225));
    rows.push_back(mk_row(RowWrite, CfgCodes, 0, 0, 0, 16'sh0000, 1, 0, 0, 0));
    rows.push_back(mk_row(RowQuery, CfgCodes, 0, 0, 0, 16'sh0000, 1, 1, 0, 0));
    rows.push_back(mk_row(RowCfg, CfgCodes, 9'd2, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(RowWrite, CfgCodes, 0, 1, 0, 16'sh0000, 0, 0, 0, 0));
    rows.push_back(mk_row(RowQuery, CfgCodes, 0, 0, 0, 16'sh0000, 1, 1, 0, 0));
    rows.push_back(mk_row(RowWrite, CfgCodes, 0, 1, 0, 16'sh0005, 0, 0, 0, 0));
    rows.push_back(mk_row(RowQuery, CfgCodes, 0, 0, 0, 16'sh0004, 1, 1, 1, 1));
    rows.push_back(mk_row(RowCfg, CfgCodes, 9'd0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(RowQuery, CfgCodes, 0, 0, 0, 16'sh0004, 1, 1, 0, 16));
    rows.push_back(mk_row(RowCfg, CfgCodes, 9'd2, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(RowCfg, CfgDims, 9'd16, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(RowFillCode, CfgCodes, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 0));
    rows.push_back(mk_row(RowFillCode, CfgCodes, 0, 1, 0, 16'sh7FFF, 0, 0, 0, 0));
    rows.push_back(mk_row(RowFillQuery, CfgCodes, 0, 0, 0, 16'sh8000, 1, 1, 0,
                          36'd68717379600));
    rows.push_back(mk_row(RowFillCode, CfgCodes, 0, 1, 0, 16'sh8000, 0, 0, 0, 0));
    rows.push_back(mk_row(RowFillQuery, CfgCodes, 0, 0, 0, 16'sh8000, 1, 1, 1, 0));
    rows.push_back(mk_row(RowFillQuery, CfgCodes, 0, 0, 0, 16'sh1234, 1, 0, 0, 0));
    rows.push_back(mk_row(RowCfg, CfgDims, 9'd31, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(RowFillQuery, CfgCodes, 0, 0, 0, -16'sd77, 1, 0, 0, 0));
    rows.push_back(mk_row(RowCfg, CfgDims, 9'd0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(RowQuery, CfgCodes, 0, 0, 0, 16'sh7FFF, 1, 0, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      r = rows[i];
      case (r.kind)
        RowCfg: write_reg(r.cfg_idx, r.cfg_val);
        RowWrite: send_item(ModeWrite, r.code, r.dim, r.val, r.last);
        RowQuery: send_item(ModeQuery, r.code, r.dim, r.val, r.last, r.typed,
                            r.exp_code, r.exp_distance);
        RowFillCode: begin
          for (int d = 0; d < active_dims(); d++)
            send_item(ModeWrite, r.code, d[DimBits-1:0], r.val, 1'b0);
        end
        RowFillQuery: begin
          for (int d = 0; d < active_dims(); d++)
            send_item(ModeQuery, CodeBits'($urandom()), d[DimBits-1:0], r.val,
                      r.last && d == active_dims() - 1, r.typed, r.exp_code, r.exp_distance);
        end
        default: ;
      endcase
    end

    for (int p = 0; p < 9; p++) begin
      if (p / 3 == 1) begin
        snd_pct = 61;
        rcv_pct = 10;
      end else if (p / 3 == 2) begin
        snd_pct = 0;
        rcv_pct = 0;
      end
      write_reg(CfgCodes, CfgDataBits'(phase_codes[p]));
      write_reg(CfgDims, CfgDataBits'(phase_dims[p]));
      count = 0;
      while (count < ItemsPhase) begin
        if ($urandom_range(9) < 7) query_sequence(count);
        else noise_item(count);
      end
    end

    in_if.valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_vq_nearest_codeword_search_core OK");
    end else begin
      $display("tb_vq_nearest_codeword_search_core NOT OK");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/vq_pkg.sv
rtl/vq_stream_if.sv
rtl/vq_cell.sv
rtl/vq_best.sv
rtl/vq_nearest_codeword_search_core.sv
tb/sv/tb_vq_nearest_codeword_search_core.sv
